@@ hdl/spb_image_stream_decoder_unit_macros.svh @@
// Assertion helpers for the stream decoder; clock clk, reset arst_n.
`ifndef SPB_IMAGE_STREAM_DECODER_UNIT_MACROS_SVH
`define SPB_IMAGE_STREAM_DECODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define SPB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SPB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/spb_isd_pkg.sv @@
package spb_isd_pkg;

	typedef enum logic [2:0] {
		KIND_W_HI,
		KIND_W_LO,
		KIND_H_HI,
		KIND_H_LO,
		KIND_DATA
	} kind_t;

	typedef struct packed {
		logic [7:0] data;
		logic       eos;
		kind_t      kind;
	} item_t;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_SEED,
		PH_CODE,
		PH_EXT,
		PH_SAMPLES,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0]  value;
		logic [1:0]  chan;
		logic [15:0] x;
		logic [15:0] y;
		logic        last;
		logic        done;
		logic        trunc;
	} result_t;

	localparam logic [2:0] HDR_BYTES   = 3'd4;
	localparam logic [3:0] SEED_BITS   = 4'd8;
	localparam logic [3:0] CODE_BITS   = 4'd3;
	localparam logic [3:0] EXT_BITS    = 4'd1;
	localparam logic [3:0] RAW_WIDTH   = 4'd8;
	localparam logic [3:0] CODE_BIAS   = 4'd2;
	localparam logic [3:0] BYTE_BITS   = 4'd8;
	localparam logic [2:0] CODE_REPEAT = 3'd0;
	localparam logic [2:0] CODE_RAW    = 3'd6;
	localparam logic [2:0] CODE_EXTEND = 3'd7;
	localparam logic [1:0] GROUP_LAST  = 2'd3;
	localparam logic [2:0] REP_COUNT   = 3'd4;
	localparam logic [1:0] CHAN_FIRST  = 2'd2;
	localparam logic [1:0] CHAN_LAST   = 2'd0;

endpackage

@@ hdl/spb_isd_front.sv @@
module spb_isd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                s_tlast,
	input  logic                q_full,
	output logic                push,
	output spb_isd_pkg::item_t  push_item
);

	logic [2:0] hdr_cnt_q;

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	// Tag the first four bytes of each stream as header bytes.
	always_comb begin
		push_item.data = s_tdata;
		push_item.eos  = s_tlast;
		unique case (hdr_cnt_q)
			3'd0:    push_item.kind = spb_isd_pkg::KIND_W_HI;
			3'd1:    push_item.kind = spb_isd_pkg::KIND_W_LO;
			3'd2:    push_item.kind = spb_isd_pkg::KIND_H_HI;
			3'd3:    push_item.kind = spb_isd_pkg::KIND_H_LO;
			default: push_item.kind = spb_isd_pkg::KIND_DATA;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q <= 3'd0;
		end else if (push) begin
			if (s_tlast) begin
				hdr_cnt_q <= 3'd0;
			end else if (hdr_cnt_q != spb_isd_pkg::HDR_BYTES) begin
				hdr_cnt_q <= hdr_cnt_q + 3'd1;
			end
		end
	end

endmodule

@@ hdl/spb_isd_queue.sv @@
module spb_isd_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  spb_isd_pkg::item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               valid,
	output spb_isd_pkg::item_t pop_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	spb_isd_pkg::item_t mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full     = cnt_q == CNT_W'(DEPTH);
	assign valid    = cnt_q != '0;
	assign pop_item = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ hdl/spb_isd_back.sv @@
module spb_isd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  spb_isd_pkg::item_t   in_item,
	output logic                 in_pop,
	output logic                 out_valid,
	output spb_isd_pkg::result_t out_res,
	input  logic                 out_ready
);

	// decoder state
	logic [15:0]          width_q, width_n;
	logic [15:0]          height_q, height_n;
	logic [31:0]          total_q, total_n;
	logic [15:0]          bitbuf_q, bitbuf_n;
	logic [3:0]           held_q, held_n;
	logic [1:0]           chan_q, chan_n;
	spb_isd_pkg::phase_t  phase_q, phase_n;
	logic [3:0]           swidth_q, swidth_n;
	logic [1:0]           grp_q, grp_n;
	logic [7:0]           run_q, run_n;
	logic [31:0]          pos_q, pos_n;
	logic [15:0]          col_q, col_n;
	logic [15:0]          row_q, row_n;
	logic [2:0]           rep_q, rep_n;
	logic                 busy_q, busy_n;
	logic                 eos_q, eos_n;
	logic                 trunc_sent_q, trunc_sent_n;
	logic                 pend_valid_q, pend_valid_n;
	spb_isd_pkg::result_t pend_q, pend_n;
	logic                 out_valid_q;
	spb_isd_pkg::result_t out_q;

	// step helpers
	logic [3:0]           needed;
	logic                 in_decode;
	logic                 can_step;
	logic [3:0]           held_take;
	logic [15:0]          field;
	logic [7:0]           t8;
	logic [7:0]           half;
	logic [7:0]           delta_val;
	logic                 em_ok;
	logic [31:0]          pos_inc;
	logic [31:0]          pos_after;
	logic                 plane_end;
	logic [15:0]          em_x;
	logic                 col_wrap;
	logic [15:0]          h_new;
	logic [31:0]          prod;
	logic                 do_emit;
	logic                 do_check;
	logic [7:0]           v_emit;
	logic                 gen;
	spb_isd_pkg::result_t gen_res;
	logic                 finish;
	logic                 send;
	spb_isd_pkg::result_t send_res;
	logic                 out_free;
	logic                 go;

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		unique case (phase_q)
			spb_isd_pkg::PH_SEED: needed = spb_isd_pkg::SEED_BITS;
			spb_isd_pkg::PH_CODE: needed = spb_isd_pkg::CODE_BITS;
			spb_isd_pkg::PH_EXT:  needed = spb_isd_pkg::EXT_BITS;
			default:              needed = swidth_q;
		endcase
		in_decode = (phase_q == spb_isd_pkg::PH_SEED) || (phase_q == spb_isd_pkg::PH_CODE) ||
			(phase_q == spb_isd_pkg::PH_EXT) || (phase_q == spb_isd_pkg::PH_SAMPLES);
		can_step  = in_decode && (held_q >= needed);
		held_take = held_q - needed;
		field     = (bitbuf_q >> held_take) & ((16'd1 << needed) - 16'd1);
		t8        = field[7:0];
		half      = {1'b0, t8[7:1]};
		if (swidth_q == spb_isd_pkg::RAW_WIDTH) begin
			delta_val = t8;
		end else if (t8[0]) begin
			delta_val = run_q + half + 8'd1;
		end else begin
			delta_val = run_q - half;
		end
		em_ok     = pos_q != total_q;
		pos_inc   = pos_q + 32'd1;
		pos_after = em_ok ? pos_inc : pos_q;
		plane_end = pos_after == total_q;
		em_x      = row_q[0] ? (width_q - 16'd1 - col_q) : col_q;
		col_wrap  = (col_q + 16'd1) == width_q;
		h_new     = {height_q[7:0], in_item.data};
		prod      = {16'd0, width_q} * {16'd0, h_new};
	end

	always_comb begin
		width_n      = width_q;
		height_n     = height_q;
		total_n      = total_q;
		bitbuf_n     = bitbuf_q;
		held_n       = held_q;
		chan_n       = chan_q;
		phase_n      = phase_q;
		swidth_n     = swidth_q;
		grp_n        = grp_q;
		run_n        = run_q;
		pos_n        = pos_q;
		col_n        = col_q;
		row_n        = row_q;
		rep_n        = rep_q;
		busy_n       = busy_q;
		eos_n        = eos_q;
		trunc_sent_n = trunc_sent_q;
		pend_valid_n = pend_valid_q;
		pend_n       = pend_q;
		in_pop       = 1'b0;
		do_emit      = 1'b0;
		do_check     = 1'b0;
		v_emit       = run_q;
		gen          = 1'b0;
		gen_res      = '0;
		finish       = 1'b0;
		send         = 1'b0;
		send_res     = pend_q;

		if (!busy_q) begin
			in_pop = in_valid;
			if (in_valid) begin
				busy_n       = 1'b1;
				eos_n        = in_item.eos;
				trunc_sent_n = 1'b0;
				unique case (in_item.kind)
					spb_isd_pkg::KIND_W_HI, spb_isd_pkg::KIND_W_LO: begin
						width_n = {width_q[7:0], in_item.data};
					end
					spb_isd_pkg::KIND_H_HI: begin
						height_n = h_new;
					end
					spb_isd_pkg::KIND_H_LO: begin
						height_n = h_new;
						total_n  = prod;
						chan_n   = spb_isd_pkg::CHAN_FIRST;
						phase_n  = ((width_q != 16'd0) && (h_new != 16'd0)) ?
							spb_isd_pkg::PH_SEED : spb_isd_pkg::PH_DONE;
					end
					default: begin
						if (in_decode) begin
							bitbuf_n = {bitbuf_q[7:0], in_item.data};
							held_n   = held_q + spb_isd_pkg::BYTE_BITS;
						end
					end
				endcase
			end
		end else begin
			priority if (rep_q != 3'd0) begin
				// repeat group: one sample a cycle while the output side does not stall
				do_emit = 1'b1;
				rep_n   = rep_q - 3'd1;
				do_check = rep_q == 3'd1;
			end else if (can_step) begin
				held_n = held_take;
				unique case (phase_q)
					spb_isd_pkg::PH_SEED: begin
						run_n    = t8;
						v_emit   = t8;
						do_emit  = 1'b1;
						phase_n  = spb_isd_pkg::PH_CODE;
						do_check = 1'b1;
					end
					spb_isd_pkg::PH_CODE: begin
						priority if (field[2:0] == spb_isd_pkg::CODE_REPEAT) begin
							rep_n = spb_isd_pkg::REP_COUNT;
						end else if (field[2:0] == spb_isd_pkg::CODE_EXTEND) begin
							phase_n = spb_isd_pkg::PH_EXT;
						end else begin
							swidth_n = (field[2:0] == spb_isd_pkg::CODE_RAW) ?
								spb_isd_pkg::RAW_WIDTH :
								{1'b0, field[2:0]} + spb_isd_pkg::CODE_BIAS;
							grp_n   = 2'd0;
							phase_n = spb_isd_pkg::PH_SAMPLES;
						end
					end
					spb_isd_pkg::PH_EXT: begin
						swidth_n = {3'b000, field[0]} + 4'd1;
						grp_n    = 2'd0;
						phase_n  = spb_isd_pkg::PH_SAMPLES;
					end
					default: begin
						run_n   = delta_val;
						v_emit  = delta_val;
						do_emit = 1'b1;
						if (grp_q == spb_isd_pkg::GROUP_LAST) begin
							grp_n    = 2'd0;
							phase_n  = spb_isd_pkg::PH_CODE;
							do_check = 1'b1;
						end else begin
							grp_n = grp_q + 2'd1;
						end
					end
				endcase
			end else if (eos_q && (phase_q != spb_isd_pkg::PH_DONE) && !trunc_sent_q) begin
				gen           = 1'b1;
				gen_res.chan  = chan_q;
				gen_res.trunc = 1'b1;
				trunc_sent_n  = 1'b1;
			end else begin
				finish = 1'b1;
			end

			if (do_emit && em_ok) begin
				gen           = 1'b1;
				gen_res.value = v_emit;
				gen_res.chan  = chan_q;
				gen_res.x     = em_x;
				gen_res.y     = row_q;
				gen_res.done  = (chan_q == spb_isd_pkg::CHAN_LAST) && (pos_inc == total_q);
				pos_n         = pos_inc;
				if (col_wrap) begin
					col_n = 16'd0;
					row_n = row_q + 16'd1;
				end else begin
					col_n = col_q + 16'd1;
				end
			end

			// advance to the next plane, or stop after the last one
			if (do_check && plane_end) begin
				if (chan_q == spb_isd_pkg::CHAN_LAST) begin
					phase_n = spb_isd_pkg::PH_DONE;
				end else begin
					chan_n  = chan_q - 2'd1;
					pos_n   = 32'd0;
					col_n   = 16'd0;
					row_n   = 16'd0;
					grp_n   = 2'd0;
					phase_n = spb_isd_pkg::PH_SEED;
				end
			end

			if (gen) begin
				if (pend_valid_q) begin
					send = 1'b1;
				end
				pend_n       = gen_res;
				pend_valid_n = 1'b1;
			end

			if (finish) begin
				if (pend_valid_q) begin
					send          = 1'b1;
					send_res.last = 1'b1;
				end
				pend_valid_n = 1'b0;
				busy_n       = 1'b0;
				if (eos_q) begin
					width_n  = 16'd0;
					height_n = 16'd0;
					total_n  = 32'd0;
					bitbuf_n = 16'd0;
					held_n   = 4'd0;
					chan_n   = spb_isd_pkg::CHAN_FIRST;
					phase_n  = spb_isd_pkg::PH_HEADER;
					swidth_n = 4'd0;
					grp_n    = 2'd0;
					run_n    = 8'd0;
					pos_n    = 32'd0;
					col_n    = 16'd0;
					row_n    = 16'd0;
					rep_n    = 3'd0;
				end
			end
		end
		go = !send || out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= 16'd0;
			height_q     <= 16'd0;
			total_q      <= 32'd0;
			bitbuf_q     <= 16'd0;
			held_q       <= 4'd0;
			chan_q       <= spb_isd_pkg::CHAN_FIRST;
			phase_q      <= spb_isd_pkg::PH_HEADER;
			swidth_q     <= 4'd0;
			grp_q        <= 2'd0;
			run_q        <= 8'd0;
			pos_q        <= 32'd0;
			col_q        <= 16'd0;
			row_q        <= 16'd0;
			rep_q        <= 3'd0;
			busy_q       <= 1'b0;
			eos_q        <= 1'b0;
			trunc_sent_q <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (go) begin
				width_q      <= width_n;
				height_q     <= height_n;
				total_q      <= total_n;
				bitbuf_q     <= bitbuf_n;
				held_q       <= held_n;
				chan_q       <= chan_n;
				phase_q      <= phase_n;
				swidth_q     <= swidth_n;
				grp_q        <= grp_n;
				run_q        <= run_n;
				pos_q        <= pos_n;
				col_q        <= col_n;
				row_q        <= row_n;
				rep_q        <= rep_n;
				busy_q       <= busy_n;
				eos_q        <= eos_n;
				trunc_sent_q <= trunc_sent_n;
				pend_valid_q <= pend_valid_n;
			end
			if (send && go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			pend_q <= pend_n;
		end
		if (send && go) begin
			out_q <= send_res;
		end
	end

endmodule

@@ hdl/spb_image_stream_decoder_unit.sv @@
// Streaming image decoder: takes the compressed stream one byte per input item
// (tlast marks the final byte) and gives one output item per decoded channel
// sample, with its serpentine pixel position, plus one truncation item when the
// stream ends before the image is complete. A front stage tags the four header
// bytes and pushes every item into a QUEUE_DEPTH-entry queue; the back stage
// pops one byte at a time and runs a sequencer that does one bit-field read or
// one repeated sample per clock, unless the output side stalls. Output items
// pass through a one-item holding register, so the last item of each byte can
// carry tlast, and then an output register. The front keeps taking bytes while
// the queue has room.
`include "spb_image_stream_decoder_unit_macros.svh"

module spb_image_stream_decoder_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic        s_tlast,  // end_of_stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // [7:0] sample_value, [9:8] channel,
	                              // [25:10] pixel_x, [41:26] pixel_y, [47:42] zero
	output logic        m_tlast,  // last_of_run
	output logic [1:0]  m_tuser   // [0] image_done, [1] truncated
);

	spb_isd_pkg::item_t   push_item;
	spb_isd_pkg::item_t   pop_item;
	spb_isd_pkg::result_t res;
	logic                 push;
	logic                 q_full;
	logic                 q_valid;
	logic                 pop;

	// Tag header bytes and queue every accepted byte.
	spb_isd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// Decouple byte intake from the decode sequencer.
	spb_isd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.valid     (q_valid),
		.pop_item  (pop_item)
	);

	// Decode the bit stream and drive the output register.
	spb_isd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (q_valid),
		.in_item   (pop_item),
		.in_pop    (pop),
		.out_valid (m_tvalid),
		.out_res   (res),
		.out_ready (m_tready)
	);

	// Pack result fields from the lowest bit up.
	assign m_tdata = {6'b000000, res.y, res.x, res.chan, res.value};
	assign m_tlast = res.last;
	assign m_tuser = {res.trunc, res.done};

	`SPB_ASSERT_NOW(a_trunc_is_last, m_tvalid && m_tuser[1], m_tlast && (m_tdata[41:0] == 42'd0 || m_tdata[9:8] != 2'd0) && !m_tuser[0] && m_tdata[7:0] == 8'd0 && m_tdata[41:10] == 32'd0, "truncation item must be last and carry no sample")
	`SPB_ASSERT_NOW(a_done_on_last_plane, m_tvalid && m_tuser[0], m_tdata[9:8] == spb_isd_pkg::CHAN_LAST && !m_tuser[1], "image done flag outside the last plane")
	`SPB_ASSERT_NEXT(a_queue_holds_item, push && !pop, q_valid, "queue lost a pushed byte")

endmodule

@@ bench/tb_spb_image_stream_decoder_unit.sv @@
`timescale 1ns / 100ps

// Tracks decoder state for the expected side and holds the results still owed by the block.
class spb_decode_scoreboard;
	spb_isd_pkg::result_t owed_q[$];
	spb_isd_pkg::result_t step_q[$];
	int                   error_count;
	logic [2:0]           hdr_count;
	logic [15:0]          img_w;
	logic [15:0]          img_h;
	logic [15:0]          bit_buf;
	logic [4:0]           bits_held;
	logic [3:0]           sample_w;
	logic [1:0]           chan;
	logic [1:0]           grp;
	logic [7:0]           run_val;
	logic [31:0]          plane_pos;
	logic [15:0]          col;
	logic [15:0]          row;
	spb_isd_pkg::phase_t  phase;

	function new();
		error_count = 0;
		owed_q.delete();
		clear_state();
	endfunction

	function void clear_state();
		hdr_count = '0;
		img_w     = '0;
		img_h     = '0;
		bit_buf   = '0;
		bits_held = '0;
		sample_w  = '0;
		chan      = spb_isd_pkg::CHAN_FIRST;
		grp       = '0;
		run_val   = '0;
		plane_pos = '0;
		col       = '0;
		row       = '0;
		phase     = spb_isd_pkg::PH_HEADER;
	endfunction

	function int outstanding();
		return owed_q.size();
	endfunction

	function logic [31:0] pixel_count();
		return {16'd0, img_w} * {16'd0, img_h};
	endfunction

	function logic [15:0] take_bits(logic [3:0] n);
		bits_held = bits_held - n;
		return (bit_buf >> bits_held) & ((16'd1 << n) - 16'd1);
	endfunction

	function logic [3:0] bits_wanted();
		case (phase)
			spb_isd_pkg::PH_SEED: return spb_isd_pkg::SEED_BITS;
			spb_isd_pkg::PH_CODE: return spb_isd_pkg::CODE_BITS;
			spb_isd_pkg::PH_EXT:  return spb_isd_pkg::EXT_BITS;
			default:              return sample_w;
		endcase
	endfunction

	// Drop samples past the end of the plane; otherwise place them in serpentine order.
	function void put_sample(logic [7:0] v);
		spb_isd_pkg::result_t r;
		if (plane_pos >= pixel_count())
			return;
		r       = '0;
		r.value = v;
		r.chan  = chan;
		r.x     = row[0] ? img_w - 16'd1 - col : col;
		r.y     = row;
		plane_pos++;
		r.done  = (chan == spb_isd_pkg::CHAN_LAST) && (plane_pos == pixel_count());
		step_q.push_back(r);
		col++;
		if (col >= img_w) begin
			col = '0;
			row++;
		end
	endfunction

	function void close_plane();
		if (plane_pos < pixel_count())
			return;
		if (chan == spb_isd_pkg::CHAN_LAST) begin
			phase = spb_isd_pkg::PH_DONE;
		end else begin
			chan--;
			plane_pos = '0;
			col       = '0;
			row       = '0;
			grp       = '0;
			phase     = spb_isd_pkg::PH_SEED;
		end
	endfunction

	function void run_decoder();
		logic [15:0] v;
		logic [2:0]  code;
		while (phase != spb_isd_pkg::PH_HEADER && phase != spb_isd_pkg::PH_DONE &&
			bits_held >= bits_wanted()) begin
			case (phase)
				spb_isd_pkg::PH_SEED: begin
					run_val = 8'(take_bits(spb_isd_pkg::SEED_BITS));
					put_sample(run_val);
					phase = spb_isd_pkg::PH_CODE;
					close_plane();
				end
				spb_isd_pkg::PH_CODE: begin
					code = 3'(take_bits(spb_isd_pkg::CODE_BITS));
					if (code == spb_isd_pkg::CODE_REPEAT) begin
						repeat (spb_isd_pkg::REP_COUNT) put_sample(run_val);
						close_plane();
					end else if (code == spb_isd_pkg::CODE_EXTEND) begin
						phase = spb_isd_pkg::PH_EXT;
					end else begin
						sample_w = (code == spb_isd_pkg::CODE_RAW) ? spb_isd_pkg::RAW_WIDTH :
							4'(code) + spb_isd_pkg::CODE_BIAS;
						grp      = '0;
						phase    = spb_isd_pkg::PH_SAMPLES;
					end
				end
				spb_isd_pkg::PH_EXT: begin
					sample_w = 4'(take_bits(spb_isd_pkg::EXT_BITS)) + 4'd1;
					grp      = '0;
					phase    = spb_isd_pkg::PH_SAMPLES;
				end
				default: begin
					v = take_bits(sample_w);
					if (sample_w == spb_isd_pkg::RAW_WIDTH)
						run_val = v[7:0];
					else if (v[0])
						run_val = 8'(run_val + (v >> 1) + 16'd1);
					else
						run_val = 8'(run_val - (v >> 1));
					put_sample(run_val);
					if (grp == spb_isd_pkg::GROUP_LAST) begin
						grp   = '0;
						phase = spb_isd_pkg::PH_CODE;
						close_plane();
					end else begin
						grp++;
					end
				end
			endcase
		end
	endfunction

	// Note one accepted input item and queue the results it owes.
	function void note_byte(logic [7:0] b, logic eos);
		spb_isd_pkg::result_t r;
		step_q.delete();
		if (phase == spb_isd_pkg::PH_HEADER) begin
			if (hdr_count < 3'd2)
				img_w = {img_w[7:0], b};
			else
				img_h = {img_h[7:0], b};
			hdr_count++;
			if (hdr_count >= spb_isd_pkg::HDR_BYTES) begin
				chan  = spb_isd_pkg::CHAN_FIRST;
				phase = (pixel_count() == 0) ? spb_isd_pkg::PH_DONE : spb_isd_pkg::PH_SEED;
			end
		end else if (phase != spb_isd_pkg::PH_DONE) begin
			bit_buf   = {bit_buf[7:0], b};
			bits_held = bits_held + spb_isd_pkg::BYTE_BITS;
			run_decoder();
		end
		if (eos) begin
			if (phase != spb_isd_pkg::PH_DONE) begin
				r       = '0;
				r.chan  = chan;
				r.trunc = 1'b1;
				step_q.push_back(r);
			end
			clear_state();
		end
		if (step_q.size() > 0)
			step_q[step_q.size() - 1].last = 1'b1;
		foreach (step_q[i])
			owed_q.push_back(step_q[i]);
	endfunction

	function void match_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			error_count++;
		end
	endfunction

	// Check one accepted result against the oldest owed one.
	function void check_result(spb_isd_pkg::result_t got);
		spb_isd_pkg::result_t want;
		if (owed_q.size() == 0) begin
			$error("unexpected result: sample_value %0d channel %0d pixel_x %0d pixel_y %0d",
				got.value, got.chan, got.x, got.y);
			error_count++;
			return;
		end
		want = owed_q.pop_front();
		match_field("sample_value", want.value, got.value);
		match_field("channel", want.chan, got.chan);
		match_field("pixel_x", want.x, got.x);
		match_field("pixel_y", want.y, got.y);
		match_field("last_of_run", want.last, got.last);
		match_field("image_done", want.done, got.done);
		match_field("truncated", want.trunc, got.trunc);
	endfunction
endclass

module tb_spb_image_stream_decoder_unit;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;    // [7:0] data_byte
	logic        s_tlast  = 1'b0;  // end_of_stream
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;          // [7:0] value, [9:8] channel, [25:10] x, [41:26] y
	logic        m_tlast;          // last_of_run
	logic [1:0]  m_tuser;          // [0] image_done, [1] truncated

	spb_decode_scoreboard sb;

	// Per-stream idling modes: a calm side never waits.
	bit src_calm  = 1'b1;
	bit sink_calm = 1'b1;

	logic [7:0] stream_bytes[$];
	bit         code_bits[$];
	int         fed = 0;

	spb_image_stream_decoder_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	// Run limit, far above the slowest legal run.
	initial begin
		#5_000_000;
		$display("FAIL spb_image_stream_decoder_unit");
		$finish;
	end

	// Offer one byte after a random gap; hold it until the block takes it.
	task automatic send_byte(logic [7:0] b, logic eos);
		int gap;
		gap = src_calm ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eos;
		do @(posedge clk); while (!s_tready);
		sb.note_byte(b, eos);
	endtask

	// Send the whole byte list, end of stream on the last byte; ignored tail bytes
	// do not count toward the stimulus total.
	task automatic send_stream(int ignored_tail);
		int i;
		for (i = 0; i < stream_bytes.size(); i++)
			send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
		fed += stream_bytes.size() - ignored_tail;
	endtask

	// Hold off the sender until every owed result has come out.
	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	function automatic void put_bits(int unsigned v, int n);
		int i;
		for (i = n - 1; i >= 0; i--)
			code_bits.push_back(v[i]);
	endfunction

	// Build a well-formed image: header, then three planes of seed and groups.
	// Bias 1 favors repeats, bias 2 favors the extended widths of one or two bits.
	function automatic void make_image(logic [15:0] w, logic [15:0] h, int bias);
		int          p;
		int          i;
		int          j;
		int unsigned n;
		int unsigned total;
		int unsigned wd;
		logic [2:0]  code;
		logic [7:0]  b;
		stream_bytes.delete();
		code_bits.delete();
		stream_bytes.push_back(w[15:8]);
		stream_bytes.push_back(w[7:0]);
		stream_bytes.push_back(h[15:8]);
		stream_bytes.push_back(h[7:0]);
		total = w * h;
		for (p = 0; p < 3; p++) begin
			put_bits($urandom_range(0, 255), 8);
			n = 1;
			while (n < total) begin
				code = 3'($urandom_range(0, 7));
				if (bias == 1 && $urandom_range(0, 1) == 0)
					code = spb_isd_pkg::CODE_REPEAT;
				if (bias == 2 && $urandom_range(0, 1) == 0)
					code = spb_isd_pkg::CODE_EXTEND;
				put_bits(code, 3);
				if (code != spb_isd_pkg::CODE_REPEAT) begin
					if (code == spb_isd_pkg::CODE_EXTEND) begin
						wd = $urandom_range(0, 1);
						put_bits(wd, 1);
						wd = wd + 1;
					end else begin
						wd = (code == spb_isd_pkg::CODE_RAW) ? spb_isd_pkg::RAW_WIDTH :
							code + spb_isd_pkg::CODE_BIAS;
					end
					repeat (4) put_bits($urandom(), wd);
				end
				n += 4;
			end
		end
		// Pad the final byte with random bits; the block never reads them.
		while (code_bits.size() % 8 != 0)
			code_bits.push_back($urandom_range(0, 1));
		for (i = 0; i < code_bits.size(); i += 8) begin
			for (j = 0; j < 8; j++)
				b[7 - j] = code_bits[i + j];
			stream_bytes.push_back(b);
		end
	endfunction

	// Result side: stall at random, then take one item and check it.
	initial begin
		int                   stall;
		spb_isd_pkg::result_t got;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = sink_calm ? 0 : $urandom_range(0, 18);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got       = '0;
			got.value = m_tdata[7:0];
			got.chan  = m_tdata[9:8];
			got.x     = m_tdata[25:10];
			got.y     = m_tdata[41:26];
			got.last  = m_tlast;
			got.done  = m_tuser[0];
			got.trunc = m_tuser[1];
			sb.check_result(got);
		end
	end

	initial begin
		int          pick;
		int          tail;
		int          cut;
		int          i;
		logic [15:0] w;
		logic [15:0] h;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Stream ends inside the header: one truncation item on the first channel.
		stream_bytes = '{8'h00, 8'h02, 8'h00};
		send_stream(0);
		// Zero width: nothing decodes, and the end of stream owes nothing.
		stream_bytes = '{8'h00, 8'h00, 8'h00, 8'h05, 8'h5A};
		send_stream(0);
		// One pixel: each plane is its seed alone, with extreme and middle values.
		stream_bytes = '{8'h00, 8'h01, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h80};
		send_stream(0);
		// Largest header, cut short: seed, repeat, a 3-bit group and both
		// extended widths, then truncation.
		stream_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h04, 8'hAE, 8'h3A, 8'hBC, 8'h6C};
		send_stream(0);
		hold_until_drained();

		// Random part: mostly well-formed images, some cut short, some noise.
		while (fed < 270) begin
			src_calm  = ($urandom_range(0, 3) == 0);
			sink_calm = ($urandom_range(0, 3) == 0);
			pick      = $urandom_range(0, 9);
			tail      = 0;
			if (pick < 8) begin
				w = 16'($urandom_range(1, 4));
				h = 16'($urandom_range(1, 4));
				if ($urandom_range(0, 7) == 0) begin
					w = 16'($urandom_range(5, 12));
					h = 16'($urandom_range(1, 2));
				end
				make_image(w, h, $urandom_range(0, 2));
				if (pick >= 6) begin
					// Cut anywhere, header included.
					cut = $urandom_range(1, stream_bytes.size() - 1);
					while (stream_bytes.size() > cut)
						void'(stream_bytes.pop_back());
				end else begin
					// Append bytes the finished image must ignore.
					tail = $urandom_range(0, 2);
					repeat (tail) stream_bytes.push_back(8'($urandom()));
				end
			end else begin
				stream_bytes.delete();
				repeat ($urandom_range(4, 10)) stream_bytes.push_back(8'($urandom()));
				// Force one empty dimension on half of the noise streams.
				if (pick == 9) begin
					i = $urandom_range(0, 1) * 2;
					stream_bytes[i]     = 8'h00;
					stream_bytes[i + 1] = 8'h00;
				end
			end
			send_stream(tail);
			if ($urandom_range(0, 7) == 0)
				hold_until_drained();
		end
		s_tvalid <= 1'b0;

		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.error_count == 0)
			$display("PASS spb_image_stream_decoder_unit");
		else
			$display("FAIL spb_image_stream_decoder_unit");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/spb_isd_pkg.sv
hdl/spb_isd_front.sv
hdl/spb_isd_queue.sv
hdl/spb_isd_back.sv
hdl/spb_image_stream_decoder_unit.sv
bench/tb_spb_image_stream_decoder_unit.sv
